### rtl/core/set_assoc_lru_cache_controller_core_macros.svh
// Assertion macros used by the checker of the cache controller.
`ifndef SET_ASSOC_LRU_CACHE_CONTROLLER_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_CONTROLLER_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SACC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SACC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/sacc_pkg.sv
// Package with the types and codes of the cache controller.
package sacc_pkg;

   localparam int ADDR_W = 16;
   localparam int WORD_W = 14;
   localparam int DATA_W = 32;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 88;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic REG_WRITE_ALLOCATE = 1'b0;
   localparam logic REG_WRITE_BACK = 1'b1;

   typedef enum logic [1:0] {
      EV_WRITE_BACK = 2'd0,
      EV_FILL = 2'd1,
      EV_MEM_WRITE = 2'd2,
      EV_DONE = 2'd3
   } sacc_event_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_WB,
      ST_WB_EMIT,
      ST_FILL,
      ST_FILL_EMIT,
      ST_ACCESS,
      ST_MEMWR,
      ST_DONE
   } sacc_state_type;

   typedef struct packed {
      logic tag_we;
      logic stamp_we;
      logic line_re;
      logic line_we;
      logic mem_we;
      logic valid_set;
      logic dirty_set;
      logic dirty_clr;
   } sacc_store_ctl_type;

endpackage

### rtl/core/sacc_way_cmp.sv
// Shared compare unit that walks the ways of a set one per cycle.
module sacc_way_cmp import sacc_pkg::*; #(
   parameter int NUM_WAYS = 4,
   parameter int TAG_W = 8,
   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             cmp_en,
   input  logic [WAY_W-1:0] cmp_way,
   input  logic             ent_valid,
   input  logic [TAG_W-1:0] ent_tag,
   input  logic [31:0]      ent_stamp,
   input  logic [TAG_W-1:0] acc_tag,
   output logic             hit,
   output logic [WAY_W-1:0] hit_way,
   output logic             inv_found,
   output logic [WAY_W-1:0] inv_way,
   output logic [WAY_W-1:0] lru_way,
   output logic [TAG_W-1:0] lru_tag
);

   logic             hit_ff, hit_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in;
   logic             inv_ff, inv_in;
   logic [WAY_W-1:0] inv_way_ff, inv_way_in;
   logic [WAY_W-1:0] lru_way_ff, lru_way_in;
   logic [TAG_W-1:0] lru_tag_ff, lru_tag_in;
   logic [31:0]      lru_stamp_ff, lru_stamp_in;

   always_comb begin
      hit_in = hit_ff;
      hit_way_in = hit_way_ff;
      inv_in = inv_ff;
      inv_way_in = inv_way_ff;
      lru_way_in = lru_way_ff;
      lru_tag_in = lru_tag_ff;
      lru_stamp_in = lru_stamp_ff;
      if (start) begin
         hit_in = 1'b0;
         inv_in = 1'b0;
      end else if (cmp_en) begin
         if (ent_valid && (ent_tag == acc_tag) && !hit_ff) begin
            hit_in = 1'b1;
            hit_way_in = cmp_way;
         end
         if (!ent_valid && !inv_ff) begin
            inv_in = 1'b1;
            inv_way_in = cmp_way;
         end
         if ((cmp_way == '0) || (ent_stamp < lru_stamp_ff)) begin
            lru_way_in = cmp_way;
            lru_tag_in = ent_tag;
            lru_stamp_in = ent_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
         inv_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         inv_ff <= inv_in;
      end
      hit_way_ff <= hit_way_in;
      inv_way_ff <= inv_way_in;
      lru_way_ff <= lru_way_in;
      lru_tag_ff <= lru_tag_in;
      lru_stamp_ff <= lru_stamp_in;
   end

   assign hit = hit_ff;
   assign hit_way = hit_way_ff;
   assign inv_found = inv_ff;
   assign inv_way = inv_way_ff;
   assign lru_way = lru_way_ff;
   assign lru_tag = lru_tag_ff;

endmodule

### rtl/core/sacc_store.sv
// Tag, stamp, line and backing memories with the valid and dirty flags.
module sacc_store import sacc_pkg::*; #(
   parameter int NUM_SETS = 16,
   parameter int NUM_WAYS = 4,
   parameter int WORDS_PER_LINE = 4,
   parameter int MEM_WORDS = 16384,
   parameter int TAG_W = 8,
   localparam int SLOTS = NUM_SETS * NUM_WAYS,
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int LINES_W = (SLOTS * WORDS_PER_LINE > 1) ? $clog2(SLOTS * WORDS_PER_LINE) : 1,
   localparam int MEM_AW = $clog2(MEM_WORDS)
) (
   input  logic               clock,
   input  logic               reset,
   input  sacc_store_ctl_type ctl,
   input  logic [SLOT_W-1:0]  slot_addr,
   input  logic [TAG_W-1:0]   tag_wdata,
   input  logic [31:0]        stamp_wdata,
   input  logic [LINES_W-1:0] line_raddr,
   input  logic [LINES_W-1:0] line_waddr,
   input  logic [31:0]        line_wdata,
   input  logic [MEM_AW-1:0]  mem_raddr,
   input  logic [MEM_AW-1:0]  mem_waddr,
   input  logic [31:0]        mem_wdata,
   output logic [TAG_W-1:0]   tag_rd,
   output logic [31:0]        stamp_rd,
   output logic               ent_valid,
   output logic               ent_dirty,
   output logic [31:0]        line_rd,
   output logic [31:0]        mem_rd
);

   logic [TAG_W-1:0] tag_mem [SLOTS];
   logic [31:0]      stamp_mem [SLOTS];
   logic [31:0]      line_mem [SLOTS * WORDS_PER_LINE];
   logic [31:0]      back_mem [MEM_WORDS];

   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] dirty_ff, dirty_in;
   logic [TAG_W-1:0] tag_rd_ff;
   logic [31:0]      stamp_rd_ff;
   logic             valid_rd_ff;
   logic [31:0]      line_rd_ff;
   logic [31:0]      mem_rd_ff;

   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      if (ctl.valid_set) begin
         valid_in[slot_addr] = 1'b1;
      end
      if (ctl.dirty_clr) begin
         dirty_in[slot_addr] = 1'b0;
      end
      if (ctl.dirty_set) begin
         dirty_in[slot_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.tag_we) begin
         tag_mem[slot_addr] <= tag_wdata;
      end
      if (ctl.stamp_we) begin
         stamp_mem[slot_addr] <= stamp_wdata;
      end
      tag_rd_ff <= tag_mem[slot_addr];
      stamp_rd_ff <= stamp_mem[slot_addr];
      valid_rd_ff <= valid_ff[slot_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.line_we) begin
         line_mem[line_waddr] <= line_wdata;
      end
      if (ctl.line_re) begin
         line_rd_ff <= line_mem[line_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_we) begin
         back_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= back_mem[mem_raddr];
   end

   assign tag_rd = tag_rd_ff;
   assign stamp_rd = stamp_rd_ff;
   assign ent_valid = valid_rd_ff;
   assign ent_dirty = dirty_ff[slot_addr];
   assign line_rd = line_rd_ff;
   assign mem_rd = mem_rd_ff;

endmodule

### rtl/core/set_assoc_lru_cache_controller_core.sv
// Top level of the set-associative write-back cache controller with LRU replacement.
//
//   Channel  Direction  Payload
//   req      in         tuser: kind; tdata: byte_address, write_data
//   rsp      out        tuser: event_res; tdata: event_address, read_word, was_hit,
//                       hits_so_far; tlast: last
//   csr      in         index 0 write_allocate_mode, index 1 write_back_mode
//
// After reset the backing memory is cleared one word per cycle, and no request is
// taken until that pass ends.
// A lookup reads one way per cycle through the shared compare unit.
// A write-back and a fill each move the line one word at a time.
// One request is handled at a time, and a held response stalls the sequencer.
module set_assoc_lru_cache_controller_core import sacc_pkg::*; #(
   parameter int NUM_SETS = 16,
   parameter int NUM_WAYS = 4,
   parameter int WORDS_PER_LINE = 4,
   parameter int MEM_WORDS = 16384
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // byte_address, write_data
   input  logic                   req_tuser,  // kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // event_address, read_word, was_hit, hits_so_far
   output logic [1:0]             rsp_tuser,  // event_res
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [0:0]             csr_addr,
   input  logic [0:0]             csr_wdata
);

   localparam int SLOTS = NUM_SETS * NUM_WAYS;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LINES_W = (SLOTS * WORDS_PER_LINE > 1) ? $clog2(SLOTS * WORDS_PER_LINE) : 1;
   localparam int MEM_AW = $clog2(MEM_WORDS);
   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int OFF_W = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
   localparam int TAG_W = WORD_W - $clog2(WORDS_PER_LINE) - $clog2(NUM_SETS);
   localparam int CNT_MAX = (NUM_WAYS > WORDS_PER_LINE) ? NUM_WAYS : WORDS_PER_LINE;
   localparam int CNT_W = $clog2(CNT_MAX + 1);

   sacc_state_type state_ff, state_in;

   logic [MEM_AW-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              kind_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [DATA_W-1:0] data_ff;
   logic              alloc_ff, alloc_in;
   logic              wbm_ff, wbm_in;
   logic [31:0]       hits_ff, hits_in;
   logic [31:0]       use_clock_ff, use_clock_in;
   logic [WAY_W-1:0]  slot_way_ff, slot_way_in;

   logic              out_vld_ff, out_vld_in;
   logic [1:0]        out_res_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [31:0]       out_rd_ff;
   logic              out_hit_ff;
   logic [31:0]       out_hits_ff;
   logic              out_last_ff;

   logic              req_fire;
   logic              emit;
   logic              emit_fire;
   logic [1:0]        emit_res;
   logic [ADDR_W-1:0] emit_addr;
   logic [31:0]       emit_rd;
   logic              emit_last;

   logic [WORD_W-1:0] word;
   logic [OFF_W-1:0]  off;
   logic [WORD_W-1:0] line_no;
   logic [SET_W-1:0]  set_idx;
   logic [TAG_W-1:0]  acc_tag;
   logic [SLOT_W-1:0] set_base;
   logic [SLOT_W-1:0] cur_slot;
   logic [WORD_W-1:0] fill_base;
   logic [WORD_W-1:0] victim_base;
   logic [WAY_W-1:0]  victim_way;
   logic [CNT_W-1:0]  cnt_prev;

   logic              start;
   logic              cmp_en;
   logic [WAY_W-1:0]  cmp_way;
   logic              hit;
   logic [WAY_W-1:0]  hit_way;
   logic              inv_found;
   logic [WAY_W-1:0]  inv_way;
   logic [WAY_W-1:0]  lru_way;
   logic [TAG_W-1:0]  lru_tag;

   sacc_store_ctl_type ctl;
   logic [SLOT_W-1:0]  slot_addr;
   logic [LINES_W-1:0] line_raddr;
   logic [LINES_W-1:0] line_waddr;
   logic [31:0]        line_wdata;
   logic [MEM_AW-1:0]  mem_raddr;
   logic [MEM_AW-1:0]  mem_waddr;
   logic [31:0]        mem_wdata;
   logic [TAG_W-1:0]   tag_rd;
   logic [31:0]        stamp_rd;
   logic               ent_valid;
   logic               ent_dirty;
   logic [31:0]        line_rd;
   logic [31:0]        mem_rd;

   assign word = addr_ff[ADDR_W-1:2];
   assign off = OFF_W'(word % WORDS_PER_LINE);
   assign line_no = WORD_W'(word / WORDS_PER_LINE);
   assign set_idx = SET_W'(line_no % NUM_SETS);
   assign acc_tag = TAG_W'(line_no / NUM_SETS);
   assign set_base = SLOT_W'(set_idx * NUM_WAYS);
   assign cur_slot = SLOT_W'(set_base + slot_way_ff);
   assign fill_base = WORD_W'(line_no * WORDS_PER_LINE);
   assign victim_base = WORD_W'((lru_tag * NUM_SETS + set_idx) * WORDS_PER_LINE);
   assign victim_way = inv_found ? inv_way : lru_way;
   assign cnt_prev = cnt_ff - 1'b1;

   assign req_fire = req_tvalid && req_tready;
   assign emit_fire = emit && (!out_vld_ff || rsp_tready);

   sacc_way_cmp #(
      .NUM_WAYS (NUM_WAYS),
      .TAG_W    (TAG_W)
   ) u_way_cmp (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmp_en    (cmp_en),
      .cmp_way   (cmp_way),
      .ent_valid (ent_valid),
      .ent_tag   (tag_rd),
      .ent_stamp (stamp_rd),
      .acc_tag   (acc_tag),
      .hit       (hit),
      .hit_way   (hit_way),
      .inv_found (inv_found),
      .inv_way   (inv_way),
      .lru_way   (lru_way),
      .lru_tag   (lru_tag)
   );

   sacc_store #(
      .NUM_SETS       (NUM_SETS),
      .NUM_WAYS       (NUM_WAYS),
      .WORDS_PER_LINE (WORDS_PER_LINE),
      .MEM_WORDS      (MEM_WORDS),
      .TAG_W          (TAG_W)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .slot_addr   (slot_addr),
      .tag_wdata   (acc_tag),
      .stamp_wdata (use_clock_ff),
      .line_raddr  (line_raddr),
      .line_waddr  (line_waddr),
      .line_wdata  (line_wdata),
      .mem_raddr   (mem_raddr),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .tag_rd      (tag_rd),
      .stamp_rd    (stamp_rd),
      .ent_valid   (ent_valid),
      .ent_dirty   (ent_dirty),
      .line_rd     (line_rd),
      .mem_rd      (mem_rd)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == MEM_AW'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (cnt_ff == CNT_W'(NUM_WAYS)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (hit) begin
               state_in = ST_ACCESS;
            end else if ((kind_ff == KIND_WRITE) && !alloc_ff) begin
               state_in = ST_MEMWR;
            end else if (!inv_found && ent_dirty) begin
               state_in = ST_WB;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_WB: begin
            if (cnt_ff == CNT_W'(WORDS_PER_LINE)) begin
               state_in = ST_WB_EMIT;
            end
         end
         ST_WB_EMIT: begin
            if (emit_fire) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (cnt_ff == CNT_W'(WORDS_PER_LINE)) begin
               state_in = ST_FILL_EMIT;
            end
         end
         ST_FILL_EMIT: begin
            if (emit_fire) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            if ((kind_ff == KIND_WRITE) && !wbm_ff) begin
               state_in = ST_MEMWR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MEMWR: begin
            if (emit_fire) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (emit_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      start = 1'b0;
      cmp_en = 1'b0;
      cmp_way = WAY_W'(cnt_prev);
      ctl = '0;
      slot_addr = cur_slot;
      line_raddr = LINES_W'(cur_slot * WORDS_PER_LINE + off);
      line_waddr = LINES_W'(cur_slot * WORDS_PER_LINE + off);
      line_wdata = data_ff;
      mem_raddr = MEM_AW'(32'(fill_base + cnt_ff) % MEM_WORDS);
      mem_waddr = MEM_AW'(32'(word) % MEM_WORDS);
      mem_wdata = data_ff;
      emit = 1'b0;
      emit_res = EV_DONE;
      emit_addr = addr_ff;
      emit_rd = '0;
      emit_last = 1'b0;
      clr_in = clr_ff;
      cnt_in = cnt_ff;
      hits_in = hits_ff;
      use_clock_in = use_clock_ff;
      slot_way_in = slot_way_ff;
      case (state_ff)
         ST_CLEAR: begin
            ctl.mem_we = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            start = req_fire;
            cnt_in = '0;
         end
         ST_LOOKUP: begin
            slot_addr = SLOT_W'(set_base + cnt_ff);
            cmp_en = (cnt_ff != '0);
            cnt_in = cnt_ff + 1'b1;
         end
         ST_DECIDE: begin
            slot_addr = SLOT_W'(set_base + victim_way);
            cnt_in = '0;
            if (hit) begin
               hits_in = hits_ff + 1'b1;
               slot_way_in = hit_way;
            end else begin
               slot_way_in = victim_way;
            end
         end
         ST_WB: begin
            ctl.line_re = (cnt_ff != CNT_W'(WORDS_PER_LINE));
            line_raddr = LINES_W'(cur_slot * WORDS_PER_LINE + cnt_ff);
            ctl.mem_we = (cnt_ff != '0);
            mem_waddr = MEM_AW'(32'(victim_base + cnt_prev) % MEM_WORDS);
            mem_wdata = line_rd;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_WB_EMIT: begin
            emit = 1'b1;
            emit_res = EV_WRITE_BACK;
            emit_addr = {victim_base, 2'b00};
            cnt_in = '0;
         end
         ST_FILL: begin
            ctl.line_we = (cnt_ff != '0);
            line_waddr = LINES_W'(cur_slot * WORDS_PER_LINE + cnt_prev);
            line_wdata = mem_rd;
            if (cnt_ff == CNT_W'(WORDS_PER_LINE)) begin
               ctl.tag_we = 1'b1;
               ctl.valid_set = 1'b1;
               ctl.dirty_clr = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         ST_FILL_EMIT: begin
            emit = 1'b1;
            emit_res = EV_FILL;
            emit_addr = {fill_base, 2'b00};
         end
         ST_ACCESS: begin
            ctl.stamp_we = 1'b1;
            use_clock_in = use_clock_ff + 1'b1;
            if (kind_ff == KIND_WRITE) begin
               ctl.line_we = 1'b1;
               ctl.dirty_set = wbm_ff;
            end else begin
               ctl.line_re = 1'b1;
            end
         end
         ST_MEMWR: begin
            emit = 1'b1;
            emit_res = EV_MEM_WRITE;
            emit_addr = {word, 2'b00};
            ctl.mem_we = emit_fire;
         end
         ST_DONE: begin
            emit = 1'b1;
            emit_res = EV_DONE;
            emit_rd = (kind_ff == KIND_WRITE) ? 32'd0 : line_rd;
            emit_last = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      alloc_in = alloc_ff;
      wbm_in = wbm_ff;
      if (csr_we) begin
         case (csr_addr[0])
            REG_WRITE_ALLOCATE: alloc_in = csr_wdata[0];
            REG_WRITE_BACK: wbm_in = csr_wdata[0];
            default: alloc_in = alloc_ff;
         endcase
      end
      out_vld_in = out_vld_ff;
      if (emit_fire) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         cnt_ff <= '0;
         alloc_ff <= 1'b1;
         wbm_ff <= 1'b1;
         hits_ff <= '0;
         use_clock_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         cnt_ff <= cnt_in;
         alloc_ff <= alloc_in;
         wbm_ff <= wbm_in;
         hits_ff <= hits_in;
         use_clock_ff <= use_clock_in;
         out_vld_ff <= out_vld_in;
      end
      slot_way_ff <= slot_way_in;
      if (req_fire) begin
         kind_ff <= req_tuser;
         addr_ff <= req_tdata[15:0];
         data_ff <= req_tdata[47:16];
      end
      if (emit_fire) begin
         out_res_ff <= emit_res;
         out_addr_ff <= emit_addr;
         out_rd_ff <= emit_rd;
         out_hit_ff <= hit;
         out_hits_ff <= hits_ff;
         out_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser = out_res_ff;
   assign rsp_tlast = out_last_ff;
   assign rsp_tdata = {7'd0, out_hits_ff, out_hit_ff, out_rd_ff, out_addr_ff};

endmodule

### rtl/core/sacc_checker.sv
// Port-level checker for the cache controller, bound to the top level.
`include "set_assoc_lru_cache_controller_core_macros.svh"

module sacc_checker import sacc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser,
   input logic                   rsp_tlast
);

   `SACC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped while stalled")
   `SACC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")
   `SACC_ASSERT_SAME(a_last_is_done, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tuser == EV_DONE), "last flag does not match the done event")
   `SACC_ASSERT_SAME(a_rd_only_done, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[47:16] == 32'd0, "read data on a non-final event")
   `SACC_ASSERT_SAME(a_wb_miss, clock, reset, rsp_tvalid && (rsp_tuser == EV_WRITE_BACK || rsp_tuser == EV_FILL), !rsp_tdata[48], "line transfer reported on a hit")

endmodule

bind set_assoc_lru_cache_controller_core sacc_checker u_sacc_checker (.*);
